[design/fpr_pkg.sv]
// Shared types, frame layout constants and helpers of the framed pointer report decoder.
`timescale 1ns / 1ps
package fpr_pkg;

  // Frame layout: byte positions inside one 18-byte frame.
  localparam int unsigned FrameLen = 18;
  localparam int unsigned PosW     = 5;

  localparam logic [PosW-1:0] PosSyncS     = 5'd0;
  localparam logic [PosW-1:0] PosSyncH     = 5'd1;
  localparam logic [PosW-1:0] PosSyncB     = 5'd2;
  localparam logic [PosW-1:0] PosVersion   = 5'd3;
  localparam logic [PosW-1:0] PosCommand   = 5'd4;
  localparam logic [PosW-1:0] PosLength    = 5'd6;
  localparam logic [PosW-1:0] PosDxLo      = 5'd7;
  localparam logic [PosW-1:0] PosDxHi      = 5'd8;
  localparam logic [PosW-1:0] PosDyLo      = 5'd9;
  localparam logic [PosW-1:0] PosDyHi      = 5'd10;
  localparam logic [PosW-1:0] PosWheel     = 5'd11;
  localparam logic [PosW-1:0] PosButtons   = 5'd12;
  localparam logic [PosW-1:0] PosSumEnd    = 5'd15;
  localparam logic [PosW-1:0] PosTrailerLo = 5'd16;
  localparam logic [PosW-1:0] PosLast      = 5'd17;

  // Header byte values.
  localparam logic [7:0] SyncS         = 8'h53;
  localparam logic [7:0] SyncH         = 8'h48;
  localparam logic [7:0] SyncB         = 8'h42;
  localparam logic [7:0] FrameVersion  = 8'h01;
  localparam logic [7:0] FrameCommand  = 8'h10;
  localparam logic [7:0] FramePayLen   = 8'h09;

  // Button masks: main buttons only, or main plus side buttons.
  localparam int unsigned NumButtons  = 5;
  localparam logic [NumButtons-1:0] BtnMaskMain = 5'b00111;
  localparam logic [NumButtons-1:0] BtnMaskAll  = 5'b11111;

  // Result kinds.
  localparam logic KindButton = 1'b0;
  localparam logic KindMove   = 1'b1;

  // Configuration port.
  localparam int unsigned CfgAddrW      = 3;
  localparam logic        RegSideButtons = 1'b0;

  localparam logic signed [7:0] StepMax = 8'sd127;
  localparam logic signed [7:0] StepMin = -8'sd127;

  // One accepted frame, as handed from the framer to the event generator.
  typedef struct packed {
    logic signed [15:0]      dx;
    logic signed [15:0]      dy;
    logic signed [7:0]       wheel;
    logic [NumButtons-1:0]   buttons;
  } frame_t;

  // One result beat.
  typedef struct packed {
    logic              kind;
    logic [2:0]        button_index;
    logic              pressed;
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
    logic signed [7:0] step_wheel;
    logic [8:0]        repeat_count;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BUTTONS,
    BK_MOVES
  } back_state_e;

  // Limits one movement report to the range -127..127.
  function automatic logic signed [7:0] clamp_step(input logic signed [15:0] v);
    logic signed [7:0] r;
    if (v > 16'sd127) begin
      r = StepMax;
    end else if (v < -16'sd127) begin
      r = StepMin;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

[design/framed_pointer_report_decoder.sv]
// Top level of the framed pointer report decoder: framer, frame queue, event generator, APB register.
`timescale 1ns / 1ps
// The block takes received serial bytes on the rx channel (valid/ready, one byte per beat) and
// assembles 18-byte frames that open with 'S','H','B'. A frame with version 1, command 0x10,
// length 9 and a matching 16-bit additive trailer is decoded into result beats on the out
// channel: first one press or release event per changed button (left, right, middle, and back
// and forward when side_buttons_enable is set), then runs of identical move reports clamped
// to +-127, each run as one beat with its repeat count. The final beat of a frame has last set.
// Rejected frames produce nothing.
// The framer takes one byte every cycle unless the queue is full at a frame's final byte. Accepted
// frames wait in a small queue, so bytes keep flowing while the event generator drains earlier
// frames. A frame's first result is registered through the queue, the generator's frame registers
// and the output register. The event generator handles one button event or one clamped move
// report at a time (up to 259 reports for the largest movement); the move report loop sets the
// rate whenever frames carry large movement.
// When the receiver stalls, results hold in the output register, then the generator stops,
// the queue fills, and rx_ready_o drops only on the final byte of a frame. Reset clears the
// byte position, the recorded button state (all released), the queue, the output valid flag and
// side_buttons_enable. The user must write the APB register only while idle; no logic enforces it.
module framed_pointer_report_decoder #(
  parameter int unsigned FrameQueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [2:0]                    button_index_o,
  output logic                          pressed_o,
  output logic signed [7:0]             step_x_o,
  output logic signed [7:0]             step_y_o,
  output logic signed [7:0]             step_wheel_o,
  output logic [8:0]                    repeat_count_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fpr_pkg::*;

  logic    side_en_q;
  logic    push, push_ready, q_valid, q_pop;
  frame_t  push_frame, q_frame;
  result_t result;

  // Register index is the word address; only the side button enable exists.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSideButtons) ? {31'b0, side_en_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegSideButtons)) begin
      side_en_q <= pwdata[0];
    end
  end

  fpr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .frame_o      (push_frame)
  );

  fpr_fifo #(
    .Depth (FrameQueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_frame),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_frame)
  );

  fpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_en_i     (side_en_q),
    .frame_valid_i (q_valid),
    .frame_ready_o (q_pop),
    .frame_i       (q_frame),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_o      (result)
  );

  assign kind_o         = result.kind;
  assign button_index_o = result.button_index;
  assign pressed_o      = result.pressed;
  assign step_x_o       = result.step_x;
  assign step_y_o       = result.step_y;
  assign step_wheel_o   = result.step_wheel;
  assign repeat_count_o = result.repeat_count;
  assign last_o         = result.last;

endmodule

[design/fpr_front.sv]
// Byte framer: hunts for sync, checks header and additive sum, captures the payload fields.
`timescale 1ns / 1ps
module fpr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_ready_o,
  input  logic [7:0]     rx_byte_i,
  output logic           push_o,
  input  logic           push_ready_i,
  output fpr_pkg::frame_t frame_o
);
  import fpr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic            hdr_ok_q, hdr_ok_d;
  logic [7:0]      trail_lo_q, trail_lo_d;
  frame_t          frame_q, frame_d;
  logic            accept;

  // Only the final byte of a frame needs room in the queue.
  assign rx_ready_o = !((pos_q == PosLast) && !push_ready_i);
  assign accept     = rx_valid_i && rx_ready_o;
  assign frame_o    = frame_q;

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    hdr_ok_d   = hdr_ok_q;
    trail_lo_d = trail_lo_q;
    frame_d    = frame_q;
    push_o     = 1'b0;
    if (accept) begin
      pos_d = pos_q + 5'd1;
      if (pos_q <= PosSumEnd) begin
        sum_d = sum_q + {8'h00, rx_byte_i};
      end
      case (pos_q)
        PosSyncS: begin
          if (rx_byte_i == SyncS) begin
            sum_d = {8'h00, rx_byte_i};
          end else begin
            pos_d = PosSyncS;
          end
        end
        PosSyncH, PosSyncB: begin
          // A wrong sync byte drops the partial frame; an 'S' starts a new one.
          if ((pos_q == PosSyncH && rx_byte_i != SyncH) ||
              (pos_q == PosSyncB && rx_byte_i != SyncB)) begin
            sum_d = {8'h00, rx_byte_i};
            pos_d = (rx_byte_i == SyncS) ? PosSyncH : PosSyncS;
          end
        end
        PosVersion:   hdr_ok_d = (rx_byte_i == FrameVersion);
        PosCommand:   hdr_ok_d = hdr_ok_q && (rx_byte_i == FrameCommand);
        PosLength:    hdr_ok_d = hdr_ok_q && (rx_byte_i == FramePayLen);
        PosDxLo:      frame_d.dx[7:0]  = rx_byte_i;
        PosDxHi:      frame_d.dx[15:8] = rx_byte_i;
        PosDyLo:      frame_d.dy[7:0]  = rx_byte_i;
        PosDyHi:      frame_d.dy[15:8] = rx_byte_i;
        PosWheel:     frame_d.wheel    = rx_byte_i;
        PosButtons:   frame_d.buttons  = rx_byte_i[NumButtons-1:0];
        PosTrailerLo: trail_lo_d       = rx_byte_i;
        PosLast: begin
          pos_d  = PosSyncS;
          push_o = hdr_ok_q && ({rx_byte_i, trail_lo_q} == sum_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosSyncS;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    hdr_ok_q   <= hdr_ok_d;
    trail_lo_q <= trail_lo_d;
    frame_q    <= frame_d;
  end

endmodule

[design/fpr_fifo.sv]
// Short queue of accepted frames between the framer and the event generator.
`timescale 1ns / 1ps
module fpr_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  fpr_pkg::frame_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output fpr_pkg::frame_t pop_data_o
);
  import fpr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  frame_t            store_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = store_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/fpr_back.sv]
// Event generator: button change events, then merged runs of clamped move reports.
`timescale 1ns / 1ps
module fpr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             side_en_i,
  input  logic             frame_valid_i,
  output logic             frame_ready_o,
  input  fpr_pkg::frame_t  frame_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpr_pkg::result_t result_o
);
  import fpr_pkg::*;

  back_state_e             state_q, state_d;
  logic [NumButtons-1:0]   prev_btn_q, prev_btn_d;
  logic [NumButtons-1:0]   btn_q, btn_d;
  logic [NumButtons-1:0]   pend_q, pend_d, pend_clr;
  logic signed [15:0]      dx_q, dx_d, dy_q, dy_d;
  logic signed [7:0]       dw_q, dw_d;
  logic signed [7:0]       rx_q, rx_d, ry_q, ry_d, rw_q, rw_d;
  logic [8:0]              cnt_q, cnt_d;
  logic signed [7:0]       sx, sy, sw;
  logic                    move_zero, same, emit_ok, emit;
  logic [2:0]              btn_idx;
  logic                    out_valid_q;
  result_t                 res_q, res_d;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign emit_ok     = !out_valid_q || out_ready_i;

  assign sx        = clamp_step(dx_q);
  assign sy        = clamp_step(dy_q);
  assign sw        = clamp_step({{8{dw_q[7]}}, dw_q});
  assign move_zero = (dx_q == '0) && (dy_q == '0) && (dw_q == '0);
  assign same      = (cnt_q != '0) && (sx == rx_q) && (sy == ry_q) && (sw == rw_q);

  // Lowest pending button first.
  always_comb begin
    btn_idx = '0;
    for (int i = NumButtons - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        btn_idx = 3'(i);
      end
    end
    pend_clr = pend_q & ~(NumButtons'(1) << btn_idx);
  end

  always_comb begin
    state_d       = state_q;
    prev_btn_d    = prev_btn_q;
    btn_d         = btn_q;
    pend_d        = pend_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    dw_d          = dw_q;
    rx_d          = rx_q;
    ry_d          = ry_q;
    rw_d          = rw_q;
    cnt_d         = cnt_q;
    emit          = 1'b0;
    res_d         = '0;
    frame_ready_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        frame_ready_o = 1'b1;
        if (frame_valid_i) begin
          dx_d       = frame_i.dx;
          dy_d       = frame_i.dy;
          dw_d       = frame_i.wheel;
          btn_d      = frame_i.buttons;
          pend_d     = (frame_i.buttons ^ prev_btn_q) & (side_en_i ? BtnMaskAll : BtnMaskMain);
          prev_btn_d = frame_i.buttons;
          cnt_d      = '0;
          state_d    = BK_BUTTONS;
        end
      end
      BK_BUTTONS: begin
        if (pend_q == '0) begin
          state_d = BK_MOVES;
        end else if (emit_ok) begin
          emit               = 1'b1;
          res_d.kind         = KindButton;
          res_d.button_index = btn_idx;
          res_d.pressed      = btn_q[btn_idx];
          res_d.last         = (pend_clr == '0) && move_zero;
          pend_d             = pend_clr;
        end
      end
      BK_MOVES: begin
        if (move_zero) begin
          if (cnt_q == '0) begin
            state_d = BK_IDLE;
          end else if (emit_ok) begin
            emit               = 1'b1;
            res_d.kind         = KindMove;
            res_d.step_x       = rx_q;
            res_d.step_y       = ry_q;
            res_d.step_wheel   = rw_q;
            res_d.repeat_count = cnt_q;
            res_d.last         = 1'b1;
            state_d            = BK_IDLE;
          end
        end else if (same) begin
          cnt_d = cnt_q + 9'd1;
          dx_d  = dx_q - {{8{sx[7]}}, sx};
          dy_d  = dy_q - {{8{sy[7]}}, sy};
          dw_d  = dw_q - sw;
        end else if (cnt_q == '0 || emit_ok) begin
          // A new report value closes the run in progress, if any.
          if (cnt_q != '0) begin
            emit               = 1'b1;
            res_d.kind         = KindMove;
            res_d.step_x       = rx_q;
            res_d.step_y       = ry_q;
            res_d.step_wheel   = rw_q;
            res_d.repeat_count = cnt_q;
          end
          rx_d  = sx;
          ry_d  = sy;
          rw_d  = sw;
          cnt_d = 9'd1;
          dx_d  = dx_q - {{8{sx[7]}}, sx};
          dy_d  = dy_q - {{8{sy[7]}}, sy};
          dw_d  = dw_q - sw;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      prev_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_btn_q <= prev_btn_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    btn_q  <= btn_d;
    pend_q <= pend_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    dw_q   <= dw_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    rw_q   <= rw_d;
    cnt_q  <= cnt_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule
